// ===== hdl/ffea_pkg.sv =====
// ----------------------------------------------------------------------------
// ffea_pkg
// Shared types, widths and codes of the first-fit extent allocator.
// ----------------------------------------------------------------------------
package ffea_pkg;

   localparam int MAX_EXTENTS = 64;
   localparam int IDX_W       = $clog2(MAX_EXTENTS);
   localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
   localparam int PAGE_W      = 36;
   localparam int LEN_W       = 19;
   localparam int ACT_W       = 2;
   localparam int STAT_W      = 2;
   localparam int ADDR_W      = 4;
   localparam int DATA_W      = 64;

   localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

   localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
   localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_INIT  = 2'd2;
   localparam logic [ACT_W-1:0] ACT_NONE  = 2'd3;

   localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
   localparam logic [STAT_W-1:0] ST_NO_SPACE   = 2'd1;
   localparam logic [STAT_W-1:0] ST_TABLE_FULL = 2'd2;
   localparam logic [STAT_W-1:0] ST_BAD_COUNT  = 2'd3;

   localparam logic [0:0] REG_POOL_BASE  = 1'b0;
   localparam logic [0:0] REG_POOL_PAGES = 1'b1;

   typedef struct packed {
      logic [PAGE_W-1:0] start;
      logic [LEN_W-1:0]  len;
   } entry_type;

   typedef struct packed {
      logic              done;
      logic [STAT_W-1:0] status;
      logic [PAGE_W-1:0] base;
   } result_type;

endpackage

// ===== hdl/first_fit_extent_allocator_top.sv =====
// ----------------------------------------------------------------------------
// first_fit_extent_allocator_top
// First-fit page-extent allocator with coalescing on free.
// ----------------------------------------------------------------------------
// The free-extent table sits in a ring of 64 cells that rotates once for every
// init, alloc or free transaction; the sequencer at the ring's tail trims,
// merges, inserts or removes entries as they pass. Such a transaction raises
// rsp_valid after a full rotation of the ring, the last step loading the result
// register, then the response register; a zero-page alloc or free request and
// the unused action code skip the rotation and pass through those two registers.
// A new request is taken once the previous response has been accepted.
// Registers sit at byte address 0 (pool_base_page) and 8 (pool_pages).
module first_fit_extent_allocator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ffea_pkg::ACT_W-1:0]    req_action,
   input  logic [ffea_pkg::LEN_W-1:0]    req_req_pages,
   input  logic [ffea_pkg::PAGE_W-1:0]   req_free_base_page,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ffea_pkg::STAT_W-1:0]   rsp_status,
   output logic [ffea_pkg::PAGE_W-1:0]   rsp_alloc_base_page,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ffea_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [ffea_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [ffea_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import ffea_pkg::*;

   logic [PAGE_W-1:0] pool_base_ff;
   logic [LEN_W-1:0]  pool_pages_ff;
   logic              csr_write;
   logic              busy, shift_en, start;
   entry_type         tail;
   entry_type         ring [MAX_EXTENTS];
   result_type        result;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff;
   logic [PAGE_W-1:0] rsp_base_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff  <= '0;
         pool_pages_ff <= LEN_W'(262144);
      end else if (csr_write) begin
         unique case (csr_paddr[3:3])
            REG_POOL_BASE:  pool_base_ff  <= csr_pwdata[PAGE_W-1:0];
            REG_POOL_PAGES: pool_pages_ff <= csr_pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:3])
         REG_POOL_BASE:  csr_prdata = DATA_W'(pool_base_ff);
         REG_POOL_PAGES: csr_prdata = DATA_W'(pool_pages_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign req_ready = !busy && !rsp_valid_ff && !result.done;
   assign start     = req_valid && req_ready;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_EXTENTS; gi++) begin : g_ring
         if (gi == MAX_EXTENTS - 1) begin : g_tail
            ffea_cell u_cell (.clock(clock), .shift_en(shift_en), .d(tail), .q(ring[gi]));
         end else begin : g_body
            ffea_cell u_cell (.clock(clock), .shift_en(shift_en), .d(ring[gi+1]),
                              .q(ring[gi]));
         end
      end
   endgenerate

   ffea_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .action         (req_action),
      .req_pages      (req_req_pages),
      .free_base_page (req_free_base_page),
      .pool_base_page (pool_base_ff),
      .pool_pages     (pool_pages_ff),
      .head           (ring[0]),
      .nxt            (ring[1]),
      .busy           (busy),
      .shift_en       (shift_en),
      .tail           (tail),
      .result         (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (result.done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.done) begin
         rsp_status_ff <= result.status;
         rsp_base_ff   <= result.base;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_alloc_base_page = rsp_base_ff;

endmodule

// ===== hdl/ffea_cell.sv =====
// ----------------------------------------------------------------------------
// ffea_cell
// One slot of the extent ring; takes its neighbor's entry on each shift.
// ----------------------------------------------------------------------------
module ffea_cell (
   input  logic               clock,
   input  logic               shift_en,
   input  ffea_pkg::entry_type d,
   output ffea_pkg::entry_type q
);
   import ffea_pkg::*;

   entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         entry_ff <= d;
      end
   end

   assign q = entry_ff;

endmodule

// ===== hdl/ffea_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffea_ctrl
// Pass sequencer: rotates the ring once per transaction and rewrites the
// stream at the tail to trim, merge, insert or remove entries.
// ----------------------------------------------------------------------------
module ffea_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ffea_pkg::ACT_W-1:0]    action,
   input  logic [ffea_pkg::LEN_W-1:0]    req_pages,
   input  logic [ffea_pkg::PAGE_W-1:0]   free_base_page,
   input  logic [ffea_pkg::PAGE_W-1:0]   pool_base_page,
   input  logic [ffea_pkg::LEN_W-1:0]    pool_pages,
   input  ffea_pkg::entry_type           head,
   input  ffea_pkg::entry_type           nxt,
   output logic                          busy,
   output logic                          shift_en,
   output ffea_pkg::entry_type           tail,
   output ffea_pkg::result_type          result
);
   import ffea_pkg::*;

   localparam logic S_IDLE = 1'b0;
   localparam logic S_RUN  = 1'b1;

   localparam logic [1:0] M_NORMAL  = 2'd0;
   localparam logic [1:0] M_SHIFT   = 2'd1;
   localparam logic [1:0] M_DELAY   = 2'd2;
   localparam logic [1:0] M_REPLACE = 2'd3;

   logic              state_ff, state_in;
   logic [IDX_W-1:0]  step_ff, step_in;
   logic [ACT_W-1:0]  op_ff, op_in;
   logic [LEN_W-1:0]  req_ff, req_in;
   logic [PAGE_W-1:0] fbase_ff, fbase_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [1:0]        mode_ff, mode_in;
   logic              hit_ff, hit_in;
   entry_type         buf_ff, buf_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [PAGE_W-1:0] abase_ff, abase_in;
   result_type        result_ff, result_in;

   logic              in_tbl, nxt_in_tbl, pred_here, zero_here, last;
   logic              has_pred, has_succ;
   logic [PAGE_W:0]   end_page, head_end;
   logic [LEN_W+1:0]  sum3;
   logic [LEN_W:0]    sum_p, sum_s;

   always_comb begin
      in_tbl     = {1'b0, step_ff} < count_ff;
      nxt_in_tbl = ({1'b0, step_ff} + CNT_W'(1)) < count_ff;
      last       = step_ff == IDX_W'(MAX_EXTENTS - 1);
      end_page   = {1'b0, fbase_ff} + (PAGE_W+1)'(req_ff);
      head_end   = {1'b0, head.start} + (PAGE_W+1)'(head.len);
      pred_here  = in_tbl && ({1'b0, head.start} < end_page) &&
                   (!nxt_in_tbl || ({1'b0, nxt.start} >= end_page));
      zero_here  = (step_ff == '0) &&
                   ((count_ff == '0) || ({1'b0, head.start} >= end_page));
      has_pred   = head_end == {1'b0, fbase_ff};
      sum3       = (LEN_W+2)'(head.len) + (LEN_W+2)'(req_ff) + (LEN_W+2)'(nxt.len);
      sum_p      = (LEN_W+1)'(head.len) + (LEN_W+1)'(req_ff);
      sum_s      = (LEN_W+1)'(nxt.len) + (LEN_W+1)'(req_ff);
      has_succ   = 1'b0;

      state_in  = state_ff;
      step_in   = step_ff;
      op_in     = op_ff;
      req_in    = req_ff;
      fbase_in  = fbase_ff;
      count_in  = count_ff;
      mode_in   = mode_ff;
      hit_in    = hit_ff;
      buf_in    = buf_ff;
      status_in = status_ff;
      abase_in  = abase_ff;
      result_in = '{done: 1'b0, status: status_ff, base: abase_ff};
      shift_en  = 1'b0;
      tail      = head;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = action;
               req_in   = req_pages;
               fbase_in = free_base_page;
               step_in  = '0;
               mode_in  = M_NORMAL;
               hit_in   = 1'b0;
               abase_in = '0;
               status_in = (action == ACT_ALLOC) ? ST_NO_SPACE : ST_OK;
               if (((action == ACT_ALLOC) || (action == ACT_FREE)) && req_pages == '0) begin
                  result_in = '{done: 1'b1, status: ST_BAD_COUNT, base: '0};
               end else if (action == ACT_NONE) begin
                  result_in = '{done: 1'b1, status: ST_OK, base: '0};
               end else begin
                  state_in = S_RUN;
               end
            end
         end
         S_RUN: begin
            shift_en = 1'b1;
            step_in  = step_ff + IDX_W'(1);
            case (mode_ff)
               M_SHIFT: tail = nxt;
               M_DELAY: begin
                  tail   = buf_ff;
                  buf_in = head;
               end
               M_REPLACE: begin
                  tail    = buf_ff;
                  mode_in = M_NORMAL;
               end
               default: tail = head;
            endcase
            if (mode_ff == M_NORMAL && !hit_ff) begin
               case (op_ff)
                  ACT_INIT: begin
                     hit_in   = 1'b1;
                     tail     = '{start: pool_base_page, len: pool_pages};
                     count_in = (pool_pages != '0) ? CNT_W'(1) : '0;
                  end
                  ACT_ALLOC: begin
                     if (in_tbl && head.len >= req_ff) begin
                        hit_in    = 1'b1;
                        abase_in  = head.start;
                        status_in = ST_OK;
                        if (head.len == req_ff) begin
                           tail     = nxt;
                           mode_in  = M_SHIFT;
                           count_in = count_ff - CNT_W'(1);
                        end else begin
                           tail = '{start: head.start + PAGE_W'(req_ff),
                                    len: head.len - req_ff};
                        end
                     end
                  end
                  ACT_FREE: begin
                     if (pred_here) begin
                        hit_in   = 1'b1;
                        has_succ = nxt_in_tbl && ({1'b0, nxt.start} == end_page);
                        if (has_pred && has_succ && sum3 <= (LEN_W+2)'(LEN_MAX)) begin
                           tail     = '{start: head.start, len: sum3[LEN_W-1:0]};
                           mode_in  = M_SHIFT;
                           count_in = count_ff - CNT_W'(1);
                        end else if (has_pred && sum_p <= (LEN_W+1)'(LEN_MAX)) begin
                           tail = '{start: head.start, len: sum_p[LEN_W-1:0]};
                        end else if (has_succ && sum_s <= (LEN_W+1)'(LEN_MAX)) begin
                           buf_in  = '{start: fbase_ff, len: sum_s[LEN_W-1:0]};
                           mode_in = M_REPLACE;
                        end else if (count_ff >= CNT_W'(MAX_EXTENTS)) begin
                           status_in = ST_TABLE_FULL;
                        end else begin
                           buf_in   = '{start: fbase_ff, len: req_ff};
                           mode_in  = M_DELAY;
                           count_in = count_ff + CNT_W'(1);
                        end
                     end else if (zero_here) begin
                        hit_in   = 1'b1;
                        has_succ = (count_ff != '0) && ({1'b0, head.start} == end_page);
                        if (has_succ && sum_p <= (LEN_W+1)'(LEN_MAX)) begin
                           tail = '{start: fbase_ff, len: sum_p[LEN_W-1:0]};
                        end else if (count_ff >= CNT_W'(MAX_EXTENTS)) begin
                           status_in = ST_TABLE_FULL;
                        end else begin
                           tail     = '{start: fbase_ff, len: req_ff};
                           buf_in   = head;
                           mode_in  = M_DELAY;
                           count_in = count_ff + CNT_W'(1);
                        end
                     end
                  end
                  default: ;
               endcase
            end
            if (last) begin
               state_in  = S_IDLE;
               result_in = '{done: 1'b1, status: status_in, base: abase_in};
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         result_ff <= '{done: 1'b0, status: ST_OK, base: '0};
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff   <= step_in;
      op_ff     <= op_in;
      req_ff    <= req_in;
      fbase_ff  <= fbase_in;
      mode_ff   <= mode_in;
      hit_ff    <= hit_in;
      buf_ff    <= buf_in;
      status_ff <= status_in;
      abase_ff  <= abase_in;
   end

   assign busy   = state_ff == S_RUN;
   assign result = result_ff;

endmodule

// ===== hdl/ffea_checker.sv =====
// ----------------------------------------------------------------------------
// ffea_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffea_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [ffea_pkg::STAT_W-1:0] rsp_status,
   input logic [ffea_pkg::PAGE_W-1:0] rsp_alloc_base_page
);
   import ffea_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped or changed while stalled");

   a_base_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alloc_base_page != '0 |-> rsp_status == ST_OK)
      else $error("base page on a failed transaction");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a transaction is in flight");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("request ready while a response waits");

endmodule

bind first_fit_extent_allocator_top ffea_checker u_ffea_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_status          (rsp_status),
   .rsp_alloc_base_page (rsp_alloc_base_page)
);
